// ===== design/vnhg_pkg.sv =====
// shared types, constants and the cosine weight table of the value noise height generator
package vnhg_pkg;

    localparam int COORD_W  = 16;
    localparam int POS_W    = 23;
    localparam int PROD_W   = 47;
    localparam int QUO_W    = 16;
    localparam int IDX_W    = 17;
    localparam int REM_W    = 8;
    localparam int WEIGHT_W = 16;
    localparam int NOISE_W  = 32;
    localparam int HASH_W   = 32;
    localparam int SUM_W    = 34;
    localparam int HEIGHT_W = 10;
    localparam int SEED_W   = 32;

    localparam logic [23:0] RECIP_ZOOM = 24'd14316558;
    localparam int          ZOOM       = 150;
    localparam int          ROW_STRIDE = 57;
    localparam logic signed [SEED_W-1:0] SEED_RESET = 32'sd10;

    localparam logic [HASH_W-1:0] HASH_MUL = 32'd60493;
    localparam logic [HASH_W-1:0] HASH_ADD = 32'd19990303;
    localparam logic [HASH_W-1:0] HASH_OFS = 32'd1376312589;
    localparam logic [HASH_W-1:0] HASH_MSK = 32'h7fffffff;
    localparam logic [HASH_W-1:0] Q30_ONE  = 32'h40000000;

    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [SUM_W-1:0]   sum;
    } cell_bus_t;

    typedef logic [WEIGHT_W-1:0] weight_table_t [256];

    // sin^2(pi*k/512) in q0.16, horner series in q30
    function automatic logic [WEIGHT_W-1:0] weight_entry(input int k);
        logic [63:0] th;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] sq;
        logic [63:0] w;
        th = (64'(k & 255) * 64'd3373259426) >> 9;
        x2 = (th * th) >> 30;
        t  = 64'd1073741824;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd110;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
        s  = (th * t) >> 30;
        sq = (s * s) >> 30;
        w  = (sq + 64'd8192) >> 14;
        if (w > 64'd65535)
        begin
            w = 64'd65535;
        end
        return w[WEIGHT_W-1:0];
    endfunction

    // weight indexed directly by the remainder of the division by the zoom
    function automatic weight_table_t build_weights();
        weight_table_t tbl;
        int            k;
        for (int r = 0; r < 256; r++)
        begin
            if (r < ZOOM)
            begin
                k = ((r * 65536) / ZOOM) >> 8;
            end
            else
            begin
                k = 0;
            end
            tbl[r] = weight_entry(k);
        end
        return tbl;
    endfunction

    localparam weight_table_t WEIGHT_LUT = build_weights();

endpackage

// ===== design/vnhg_hash.sv =====
// four-stage lattice corner hash giving a q2.30 noise value
module vnhg_hash
(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [vnhg_pkg::HASH_W-1:0]  lat_i,
    input  logic signed [vnhg_pkg::HASH_W-1:0]  lat_j,
    input  logic signed [vnhg_pkg::SEED_W-1:0]  seed,
    output logic signed [vnhg_pkg::NOISE_W-1:0] noise
);

    logic [vnhg_pkg::HASH_W-1:0] n_comb;
    logic [vnhg_pkg::HASH_W-1:0] m_comb;
    logic [vnhg_pkg::HASH_W-1:0] n2_reg;
    logic [vnhg_pkg::HASH_W-1:0] n2_d_reg;
    logic [vnhg_pkg::HASH_W-1:0] n2_dd_reg;
    logic [vnhg_pkg::HASH_W-1:0] sq_reg;
    logic [vnhg_pkg::HASH_W-1:0] q_reg;
    logic signed [vnhg_pkg::NOISE_W-1:0] noise_reg;

    assign n_comb = vnhg_pkg::HASH_W'(lat_i)
                  + vnhg_pkg::HASH_W'(lat_j * vnhg_pkg::HASH_W'(vnhg_pkg::ROW_STRIDE))
                  + vnhg_pkg::HASH_W'(seed);
    assign m_comb = (vnhg_pkg::HASH_W'(n2_dd_reg * q_reg) + vnhg_pkg::HASH_OFS)
                  & vnhg_pkg::HASH_MSK;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg    <= (n_comb << 13) ^ n_comb;
            sq_reg    <= vnhg_pkg::HASH_W'(n2_reg * n2_reg);
            n2_d_reg  <= n2_reg;
            q_reg     <= vnhg_pkg::HASH_W'(sq_reg * vnhg_pkg::HASH_MUL) + vnhg_pkg::HASH_ADD;
            n2_dd_reg <= n2_d_reg;
            noise_reg <= $signed(vnhg_pkg::Q30_ONE - m_comb);
        end
    end

    assign noise = noise_reg;

endmodule

// ===== design/vnhg_cell.sv =====
// one octave cell: lattice split, corner hashes, cosine blend and sum update
module vnhg_cell
#(
    parameter int LEVEL = 0
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic signed [vnhg_pkg::SEED_W-1:0] seed,
    input  vnhg_pkg::cell_bus_t                bus_in,
    output vnhg_pkg::cell_bus_t                bus_out
);

    localparam int STAGES = 9;

    vnhg_pkg::cell_bus_t bus_reg [STAGES];

    logic signed [vnhg_pkg::POS_W-1:0]  pos       [2];
    logic        [vnhg_pkg::POS_W-1:0]  abs_next  [2];
    logic        [vnhg_pkg::POS_W-1:0]  abs_reg   [2];
    logic        [vnhg_pkg::PROD_W-1:0] prod_reg  [2];
    logic                               neg_reg   [2];
    logic signed [vnhg_pkg::IDX_W-1:0]  idx_next  [2];
    logic        [vnhg_pkg::REM_W-1:0]  rem_next  [2];
    logic signed [vnhg_pkg::IDX_W-1:0]  idx_reg   [2];
    logic        [vnhg_pkg::REM_W-1:0]  rem_reg   [2];
    logic        [vnhg_pkg::WEIGHT_W-1:0] wx_reg  [4];
    logic        [vnhg_pkg::WEIGHT_W-1:0] wy_reg  [5];
    logic signed [vnhg_pkg::HASH_W-1:0] lat_i0;
    logic signed [vnhg_pkg::HASH_W-1:0] lat_i1;
    logic signed [vnhg_pkg::HASH_W-1:0] lat_j0;
    logic signed [vnhg_pkg::HASH_W-1:0] lat_j1;
    logic signed [vnhg_pkg::NOISE_W-1:0] noise_s;
    logic signed [vnhg_pkg::NOISE_W-1:0] noise_t;
    logic signed [vnhg_pkg::NOISE_W-1:0] noise_u;
    logic signed [vnhg_pkg::NOISE_W-1:0] noise_v;
    logic signed [vnhg_pkg::NOISE_W-1:0] bx0_reg;
    logic signed [vnhg_pkg::NOISE_W-1:0] bx1_reg;
    logic signed [vnhg_pkg::NOISE_W-1:0] oct_reg;
    logic signed [vnhg_pkg::SUM_W-1:0]   oct_wide;
    logic signed [vnhg_pkg::SUM_W-1:0]   oct_scaled;
    vnhg_pkg::cell_bus_t                 bus_last;

    function automatic logic signed [vnhg_pkg::NOISE_W-1:0] blend(
        input logic signed [vnhg_pkg::NOISE_W-1:0] a,
        input logic signed [vnhg_pkg::NOISE_W-1:0] b,
        input logic        [vnhg_pkg::WEIGHT_W-1:0] w
    );
        logic signed [32:0] d;
        logic signed [49:0] p;
        logic signed [49:0] q;
        d = 33'(b) - 33'(a);
        p = 50'(d) * 50'($signed({1'b0, w}));
        if (p < 0)
        begin
            p = p + 50'sd65535;
        end
        q = p >>> 16;
        return vnhg_pkg::NOISE_W'(50'(a) + q);
    endfunction

    // scaled position and its magnitude
    assign pos[0] = vnhg_pkg::POS_W'(bus_in.x) <<< LEVEL;
    assign pos[1] = vnhg_pkg::POS_W'(bus_in.y) <<< LEVEL;

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            abs_next[a] = pos[a][vnhg_pkg::POS_W-1] ? vnhg_pkg::POS_W'(-pos[a])
                                                    : vnhg_pkg::POS_W'(pos[a]);
        end
    end

    // quotient by reciprocal, one correction step, sign restored
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin : split
            logic [vnhg_pkg::QUO_W-1:0] q0;
            logic [23:0]                r0;
            logic [vnhg_pkg::QUO_W-1:0] q1;
            logic [23:0]                r1;
            logic signed [vnhg_pkg::IDX_W-1:0] mag;
            q0 = prod_reg[a][vnhg_pkg::PROD_W-1:31];
            r0 = {1'b0, abs_reg[a]} - 24'(q0 * 24'(vnhg_pkg::ZOOM));
            if (r0 >= 24'(vnhg_pkg::ZOOM))
            begin
                q1 = q0 + 1'b1;
                r1 = r0 - 24'(vnhg_pkg::ZOOM);
            end
            else
            begin
                q1 = q0;
                r1 = r0;
            end
            mag = $signed({1'b0, q1});
            idx_next[a] = neg_reg[a] ? -mag : mag;
            rem_next[a] = r1[vnhg_pkg::REM_W-1:0];
        end
    end

    assign lat_i0 = vnhg_pkg::HASH_W'(idx_reg[0]);
    assign lat_j0 = vnhg_pkg::HASH_W'(idx_reg[1]);
    assign lat_i1 = lat_i0 + 32'sd1;
    assign lat_j1 = lat_j0 + 32'sd1;

    vnhg_hash u_hash_s (.clk(clk), .en(en), .lat_i(lat_i0), .lat_j(lat_j0), .seed(seed),
                        .noise(noise_s));
    vnhg_hash u_hash_t (.clk(clk), .en(en), .lat_i(lat_i1), .lat_j(lat_j0), .seed(seed),
                        .noise(noise_t));
    vnhg_hash u_hash_u (.clk(clk), .en(en), .lat_i(lat_i0), .lat_j(lat_j1), .seed(seed),
                        .noise(noise_u));
    vnhg_hash u_hash_v (.clk(clk), .en(en), .lat_i(lat_i1), .lat_j(lat_j1), .seed(seed),
                        .noise(noise_v));

    // octave value divided by its frequency, truncated toward zero
    assign oct_wide   = vnhg_pkg::SUM_W'(oct_reg);
    assign oct_scaled = (oct_wide + (oct_reg < 0 ? vnhg_pkg::SUM_W'((1 << LEVEL) - 1)
                                                 : vnhg_pkg::SUM_W'(0))) >>> LEVEL;

    always_comb
    begin
        bus_last     = bus_reg[STAGES-2];
        bus_last.sum = bus_reg[STAGES-2].sum + oct_scaled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                bus_reg[s] <= '0;
            end
        end
        else if (en)
        begin
            bus_reg[0] <= bus_in;
            for (int s = 1; s < STAGES - 1; s++)
            begin
                bus_reg[s] <= bus_reg[s-1];
            end
            bus_reg[STAGES-1] <= bus_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 2; a++)
            begin
                abs_reg[a]  <= abs_next[a];
                neg_reg[a]  <= pos[a][vnhg_pkg::POS_W-1];
                prod_reg[a] <= vnhg_pkg::PROD_W'(abs_next[a] * vnhg_pkg::RECIP_ZOOM);
                idx_reg[a]  <= idx_next[a];
                rem_reg[a]  <= rem_next[a];
            end
            wx_reg[0] <= vnhg_pkg::WEIGHT_LUT[rem_reg[0]];
            wy_reg[0] <= vnhg_pkg::WEIGHT_LUT[rem_reg[1]];
            for (int s = 1; s < 4; s++)
            begin
                wx_reg[s] <= wx_reg[s-1];
            end
            for (int s = 1; s < 5; s++)
            begin
                wy_reg[s] <= wy_reg[s-1];
            end
            bx0_reg <= blend(noise_s, noise_t, wx_reg[3]);
            bx1_reg <= blend(noise_u, noise_v, wx_reg[3]);
            oct_reg <= blend(bx0_reg, bx1_reg, wy_reg[4]);
        end
    end

    assign bus_out = bus_reg[STAGES-1];

endmodule

// ===== design/value_noise_height_generator_unit.sv =====
// top level of the fractal value noise terrain height generator
// each request carries a signed column coordinate and yields one terrain height.
// the coordinate runs through a chain of OCTAVES cells, one per octave, that
// differ only in their level; every cell is a nine-stage pipeline (lattice
// split by reciprocal, four corner hashes, cosine blend in x then y, weighted
// add into the running sum) and hands the coordinate and partial sum to its
// neighbour each cycle the pipeline moves. a final stage maps the sum onto the
// height range and clamps it. one request is taken every clock cycle while the
// pipeline moves; it all moves together and holds only while a finished
// height sits unclaimed in the output register. the seed register resets to
// 10; write it only while no request is in flight (the block does not check).
module value_noise_height_generator_unit
#(
    parameter int MAX_HEIGHT = 112,
    parameter int OCTAVES    = 5
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // seed register
    input  logic                                 seed_we,
    input  logic signed [vnhg_pkg::SEED_W-1:0]   seed,
    // coordinate requests
    input  logic                                 coord_valid,
    output logic                                 coord_stall,
    input  logic signed [vnhg_pkg::COORD_W-1:0]  x_coord,
    input  logic signed [vnhg_pkg::COORD_W-1:0]  y_coord,
    // height results
    output logic                                 height_valid,
    input  logic                                 height_stall,
    output logic        [vnhg_pkg::HEIGHT_W-1:0] height
);

    localparam int MUL_W = vnhg_pkg::SUM_W + 11;

    logic signed [vnhg_pkg::SEED_W-1:0] seed_reg;
    logic                               hvalid_reg;
    logic [vnhg_pkg::HEIGHT_W-1:0]      height_reg;
    logic [vnhg_pkg::HEIGHT_W-1:0]      height_next;
    logic                               advance;
    vnhg_pkg::cell_bus_t                chain [OCTAVES+1];

    // pipeline moves unless a finished height is held by the consumer
    assign advance     = !(hvalid_reg && height_stall);
    assign coord_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= vnhg_pkg::SEED_RESET;
        end
        else if (seed_we)
        begin
            seed_reg <= seed;
        end
    end

    // head of the chain: fresh request with an empty octave sum
    always_comb
    begin
        chain[0].valid = coord_valid;
        chain[0].x     = x_coord;
        chain[0].y     = y_coord;
        chain[0].sum   = '0;
    end

    generate
        for (genvar g = 0; g < OCTAVES; g++)
        begin : g_octave
            vnhg_cell #(.LEVEL(g)) u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (advance),
                .seed    (seed_reg),
                .bus_in  (chain[g]),
                .bus_out (chain[g+1])
            );
        end
    endgenerate

    // height = trunc((sum + 1.0) * (MAX_HEIGHT-5) / 2) + 3, clamped
    always_comb
    begin : map_height
        logic signed [vnhg_pkg::SUM_W-1:0] biased;
        logic signed [MUL_W-1:0]           prod;
        logic signed [MUL_W-1:0]           quot;
        logic signed [15:0]                h;
        biased = chain[OCTAVES].sum + vnhg_pkg::SUM_W'(vnhg_pkg::Q30_ONE);
        prod   = MUL_W'(biased) * MUL_W'($signed({1'b0, 10'(MAX_HEIGHT - 5)}));
        if (prod < 0)
        begin
            prod = prod + MUL_W'(32'h7fffffff);
        end
        quot = prod >>> 31;
        h    = 16'(quot) + 16'sd3;
        if (h > 16'(MAX_HEIGHT - 1))
        begin
            h = 16'(MAX_HEIGHT - 1);
        end
        if (h < 16'sd2)
        begin
            h = 16'sd2;
        end
        height_next = h[vnhg_pkg::HEIGHT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            hvalid_reg <= chain[OCTAVES].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            height_reg <= height_next;
        end
    end

    assign height_valid = hvalid_reg;
    assign height       = height_reg;

endmodule
